// ----- src/pfa_pkg.sv -----
// Shared definitions for the page frame allocator: widths, command codes,
// register indexes, controller states and the per-page status record.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pfa_pkg;

  localparam int unsigned CFG_W   = 12;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PADDR_W = 3;
  // next-fit pointer may sit one past the highest page
  localparam int unsigned PTR_W   = CFG_W + 1;

  localparam int unsigned NUM_PAGES_DEF  = 4096;
  localparam int unsigned PAGE_SHIFT_DEF = 12;

  localparam logic [CFG_W-1:0] FIRST_PAGE_RST = 12'd0;
  localparam logic [CFG_W-1:0] LAST_PAGE_RST  = 12'd4095;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC     = 3'd0,
    CMD_FREE      = 3'd1,
    CMD_ALLOC_RSV = 3'd2,
    CMD_FREE_RSV  = 3'd3,
    CMD_QUERY_RSV = 3'd4,
    CMD_LOAD      = 3'd5
  } pfa_cmd_e;

  typedef enum logic {
    REG_FIRST_PAGE = 1'b0,
    REG_LAST_PAGE  = 1'b1
  } pfa_reg_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_SCAN
  } pfa_state_e;

  typedef struct packed {
    logic in_use;
    logic avail;
    logic exists;
  } pfa_status_t;

  function automatic logic is_free(input pfa_status_t s);
    return s.exists && s.avail && !s.in_use;
  endfunction

  function automatic logic is_reserved(input pfa_status_t s);
    return s.exists && !s.avail;
  endfunction

endpackage

// ----- src/pfa_if.sv -----
// Valid/ready channel interfaces for the page frame allocator:
// command channel (pfa_req_if) and response channel (pfa_rsp_if).
// Depends on pfa_pkg for field widths.
`timescale 1ns / 1ps

interface pfa_req_if;
  import pfa_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] phys_address;
  logic              load_exists;
  logic              load_available;
  logic              load_in_use;

  modport source (
    output valid, cmd, phys_address, load_exists, load_available, load_in_use,
    input  ready
  );
  modport sink (
    input  valid, cmd, phys_address, load_exists, load_available, load_in_use,
    output ready
  );
endinterface

interface pfa_rsp_if;
  import pfa_pkg::*;

  logic              valid;
  logic              ready;
  logic              ok;
  logic [ADDR_W-1:0] result_address;

  modport source (
    output valid, ok, result_address,
    input  ready
  );
  modport sink (
    input  valid, ok, result_address,
    output ready
  );
endinterface

// ----- src/page_frame_allocator_unit.sv -----
// Page frame allocator top level: status memory, command controller,
// next-fit scanner and APB register file.
// Depends on pfa_pkg and the channel interfaces in pfa_if.sv.
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// req_i     in   valid/ready          cmd, phys_address, load_exists/available/in_use
// rsp_o     out  valid/ready          ok, result_address
// APB       in   psel/penable/pready  paddr, pwdata, prdata (first_page, last_page)
//
// After reset a clearing pass writes every status entry; req_i.ready stays
// low meanwhile (APB writes are taken).
// Free, allocate reserved, free reserved, query and load: a memory read
// followed by the modify/write step through the memory write port.
// Allocate: one page per cycle through the memory read port while no response
// waits in the output register; a failing scan runs through both passes.
// A response waiting in the output register holds the controller in its RMW
// or scan state: no scan step and no memory write until it is taken.
module page_frame_allocator_unit #(
  parameter int unsigned NUM_PAGES  = pfa_pkg::NUM_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT = pfa_pkg::PAGE_SHIFT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pfa_req_if.sink                      req_i,
  pfa_rsp_if.source                    rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pfa_pkg::PADDR_W-1:0]  paddr,
  input  logic [pfa_pkg::DATA_W-1:0]   pwdata,
  output logic [pfa_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import pfa_pkg::*;

  localparam int unsigned PW = $clog2(NUM_PAGES);
  localparam logic [31:0] MAX_PAGE = 32'(NUM_PAGES - 1);

  // status memory
  pfa_status_t mem [NUM_PAGES];
  logic        mem_we, mem_re;
  logic [PW-1:0] mem_waddr, mem_raddr;
  pfa_status_t mem_wdata;
  pfa_status_t rdata_q;

  pfa_state_e state_q, state_d;
  logic [PW-1:0] clr_cnt_q, clr_cnt_d;
  logic [CFG_W-1:0] first_page_q, first_page_d, last_page_q, last_page_d;
  logic [PTR_W-1:0] next_page_q, next_page_d;

  // latched command
  logic [CMD_W-1:0] cmd_q, cmd_d;
  logic [PW-1:0] pg_q, pg_d;
  logic pg_vld_q, pg_vld_d;
  pfa_status_t load_q, load_d;

  // scanner
  logic [PTR_W-1:0] ptr_q, ptr_d, chk_page_q, chk_page_d, scan_hi;
  logic pass_q, pass_d, chk_vld_q, chk_vld_d;
  logic scan_hit, scan_more, scan_fail;

  // output register
  logic out_valid_q, out_valid_d, ok_q, ok_d;
  logic [ADDR_W-1:0] res_q, res_d;
  logic out_free, emit, emit_ok;
  logic [ADDR_W-1:0] emit_addr, rsv_addr, hit_addr;

  logic req_acc, cfg_wr, clr_done;
  logic [31:0] req_page;

  assign req_acc  = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_page = req_i.phys_address >> PAGE_SHIFT;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LAST_PAGE) ? DATA_W'(last_page_q) : DATA_W'(first_page_q);

  assign clr_done = (clr_cnt_q == PW'(NUM_PAGES - 1));
  assign out_free = !out_valid_q || rsp_o.ready;

  // scan stops at the last page or the end of the store, whichever is lower
  assign scan_hi   = (32'(last_page_q) > MAX_PAGE) ? MAX_PAGE[PTR_W-1:0]
                                                   : PTR_W'(last_page_q);
  assign scan_hit  = chk_vld_q && (chk_page_q != '0) && is_free(rdata_q);
  assign scan_more = (ptr_q <= scan_hi);
  assign scan_fail = !scan_hit && !scan_more && !chk_vld_q && pass_q;

  assign rsv_addr = ADDR_W'(64'(pg_q) << PAGE_SHIFT);
  assign hit_addr = ADDR_W'(64'(chk_page_q) << PAGE_SHIFT);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_acc) state_d = (req_i.cmd == CMD_ALLOC) ? ST_SCAN : ST_RMW;
      end
      ST_RMW: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (out_free && (scan_hit || scan_fail)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = clr_cnt_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = PW'(req_page);
    clr_cnt_d   = clr_cnt_q;
    cmd_d       = cmd_q;
    pg_d        = pg_q;
    pg_vld_d    = pg_vld_q;
    load_d      = load_q;
    ptr_d       = ptr_q;
    pass_d      = pass_q;
    chk_vld_d   = chk_vld_q;
    chk_page_d  = chk_page_q;
    next_page_d = next_page_q;
    emit        = 1'b0;
    emit_ok     = 1'b0;
    emit_addr   = '0;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
      ST_IDLE: begin
        if (req_acc) begin
          cmd_d    = req_i.cmd;
          pg_d     = PW'(req_page);
          pg_vld_d = (req_page != '0) && (req_page < 32'(NUM_PAGES));
          load_d   = '{in_use: req_i.load_in_use, avail: req_i.load_available,
                       exists: req_i.load_exists};
          if (req_i.cmd == CMD_ALLOC) begin
            ptr_d     = next_page_q;
            pass_d    = 1'b0;
            chk_vld_d = 1'b0;
          end else begin
            mem_re = 1'b1;
          end
        end
      end
      ST_RMW: begin
        if (out_free) begin
          emit      = 1'b1;
          mem_waddr = pg_q;
          mem_wdata = rdata_q;
          if (pg_vld_q) begin
            case (cmd_q)
              CMD_FREE: begin
                if (rdata_q.exists && rdata_q.avail && rdata_q.in_use) begin
                  mem_we           = 1'b1;
                  mem_wdata.in_use = 1'b0;
                  emit_ok          = 1'b1;
                end
              end
              CMD_ALLOC_RSV: begin
                if (is_reserved(rdata_q) && !rdata_q.in_use) begin
                  mem_we           = 1'b1;
                  mem_wdata.in_use = 1'b1;
                  emit_ok          = 1'b1;
                  emit_addr        = rsv_addr;
                end
              end
              CMD_FREE_RSV: begin
                if (is_reserved(rdata_q) && rdata_q.in_use) begin
                  mem_we           = 1'b1;
                  mem_wdata.in_use = 1'b0;
                  emit_ok          = 1'b1;
                end
              end
              CMD_QUERY_RSV: emit_ok = is_reserved(rdata_q);
              CMD_LOAD: begin
                mem_we    = 1'b1;
                mem_wdata = load_q;
                emit_ok   = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end
      ST_SCAN: begin
        // read at ptr issued while the scan goes on, checked on the registered read data
        if (out_free) begin
          if (scan_hit) begin
            mem_we           = 1'b1;
            mem_waddr        = PW'(chk_page_q);
            mem_wdata        = rdata_q;
            mem_wdata.in_use = 1'b1;
            next_page_d      = chk_page_q + 1'b1;
            chk_vld_d        = 1'b0;
            emit             = 1'b1;
            emit_ok          = 1'b1;
            emit_addr        = hit_addr;
          end else if (scan_more) begin
            mem_re     = 1'b1;
            mem_raddr  = PW'(ptr_q);
            chk_vld_d  = 1'b1;
            chk_page_d = ptr_q;
            ptr_d      = ptr_q + 1'b1;
          end else if (chk_vld_q) begin
            chk_vld_d = 1'b0;
          end else if (!pass_q) begin
            pass_d = 1'b1;
            ptr_d  = PTR_W'(first_page_q);
          end else begin
            next_page_d = PTR_W'(first_page_q);
            emit        = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (cfg_wr && paddr[2] == REG_FIRST_PAGE) next_page_d = PTR_W'(pwdata[CFG_W-1:0]);
  end

  always_comb begin
    first_page_d = first_page_q;
    last_page_d  = last_page_q;
    if (cfg_wr) begin
      if (paddr[2] == REG_FIRST_PAGE) first_page_d = pwdata[CFG_W-1:0];
      else last_page_d = pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !rsp_o.ready;
    ok_d        = ok_q;
    res_d       = res_q;
    if (emit) begin
      out_valid_d = 1'b1;
      ok_d        = emit_ok;
      res_d       = emit_addr;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.ok             = ok_q;
  assign rsp_o.result_address = res_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      first_page_q <= FIRST_PAGE_RST;
      last_page_q  <= LAST_PAGE_RST;
      next_page_q  <= '0;
      ptr_q        <= '0;
      pass_q       <= 1'b0;
      chk_vld_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      first_page_q <= first_page_d;
      last_page_q  <= last_page_d;
      next_page_q  <= next_page_d;
      ptr_q        <= ptr_d;
      pass_q       <= pass_d;
      chk_vld_q    <= chk_vld_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    pg_q       <= pg_d;
    pg_vld_q   <= pg_vld_d;
    load_q     <= load_d;
    chk_page_q <= chk_page_d;
    ok_q       <= ok_d;
    res_q      <= res_d;
  end

endmodule

// ----- src/pfa_checker.sv -----
// Port-level checks for the page frame allocator, attached by bind.
// Depends on pfa_pkg and on page_frame_allocator_unit.
`timescale 1ns / 1ps

module pfa_checker #(
  parameter int unsigned PAGE_SHIFT = pfa_pkg::PAGE_SHIFT_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        ok_i,
  input logic [pfa_pkg::ADDR_W-1:0]  result_address_i
);
  import pfa_pkg::*;

  // a stalled response stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("response dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(ok_i) && $stable(result_address_i))
    else $error("response payload changed while stalled");

  // failed responses carry a zero address
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ok_i |-> result_address_i == '0)
    else $error("address on a failed response");

  a_page_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> result_address_i[PAGE_SHIFT-1:0] == '0)
    else $error("result address not page aligned");

  // one command in flight: ready drops after each accepted command
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command accepted back to back");

endmodule

bind page_frame_allocator_unit pfa_checker #(
  .PAGE_SHIFT(PAGE_SHIFT)
) u_pfa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (req_i.valid),
  .in_ready_i       (req_i.ready),
  .out_valid_i      (rsp_o.valid),
  .out_ready_i      (rsp_o.ready),
  .ok_i             (rsp_o.ok),
  .result_address_i (rsp_o.result_address)
);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for page_frame_allocator_unit: directed and random
// commands across several first_page/last_page settings, checked in order.
// Depends on pfa_pkg and the channel interfaces in pfa_if.sv.
`timescale 1ns / 1ps

module testbench;
  import pfa_pkg::*;

  localparam int unsigned NUM_PAGES      = NUM_PAGES_DEF;
  localparam int unsigned PAGE_SHIFT     = PAGE_SHIFT_DEF;
  localparam int          WATCHDOG_LIMIT = 40000;
  localparam int          MAX_PRINTED    = 100;

  // command codes the block leaves unused
  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

  // receiver stall patterns
  localparam int RX_FREE   = 0;
  localparam int RX_CHOPPY = 1;
  localparam int RX_STALLY = 2;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic              ld_exists;
    logic              ld_avail;
    logic              ld_in_use;
  } frame_cmd_t;

  typedef struct {
    logic              ok;
    logic [ADDR_W-1:0] addr;
  } frame_reply_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  pfa_req_if req_bus ();
  pfa_rsp_if rsp_bus ();

  page_frame_allocator_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  pfa_status_t        frame_status [NUM_PAGES];
  logic [PTR_W-1:0]   scan_ptr;
  logic [CFG_W-1:0]   cfg_first;
  logic [CFG_W-1:0]   cfg_last;

  frame_cmd_t   cmd_backlog[$];
  frame_reply_t pending_replies[$];

  int  n_queued      = 0;
  int  n_accepted    = 0;
  int  n_errors      = 0;
  int  n_alloc       = 0;
  int  n_alloc_ok    = 0;
  int  n_ok          = 0;
  int  n_settings    = 0;
  int  burst_left    = 1;
  int  gap_left      = 0;
  int  rx_mode       = RX_FREE;
  int  rx_mode_left  = 0;
  int  idle_cycles   = 0;
  bit  req_taken     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MAX_PRINTED) $display("%0t MISMATCH: %s", $time, msg);
  endtask

  function automatic logic [ADDR_W-1:0] frame_addr(input int pg);
    return ADDR_W'(pg) << PAGE_SHIFT;
  endfunction

  // first free page in lo..hi, -1 if none; page zero never qualifies
  function automatic int find_free(input int lo, input int hi);
    for (int p = lo; p <= hi && p < NUM_PAGES; p++) begin
      if (p != 0 && frame_status[p].exists && frame_status[p].avail &&
          !frame_status[p].in_use) return p;
    end
    return -1;
  endfunction

  function automatic frame_reply_t frame_alloc_step(input frame_cmd_t rq);
    frame_reply_t rs;
    logic [ADDR_W-PAGE_SHIFT-1:0] pg;
    pfa_status_t st;
    logic reserved;
    int hit;
    rs.ok   = 1'b0;
    rs.addr = '0;
    pg      = rq.addr[ADDR_W-1:PAGE_SHIFT];
    if (rq.cmd == CMD_ALLOC) begin
      hit = find_free(int'(scan_ptr), int'(cfg_last));
      if (hit < 0) hit = find_free(int'(cfg_first), int'(cfg_last));
      if (hit >= 0) begin
        frame_status[hit].in_use = 1'b1;
        scan_ptr = PTR_W'(hit + 1);
        rs.ok    = 1'b1;
        rs.addr  = frame_addr(hit);
      end else begin
        scan_ptr = PTR_W'(cfg_first);
      end
    end else if (rq.cmd <= CMD_LOAD && pg != 0 && pg < NUM_PAGES) begin
      st       = frame_status[pg];
      reserved = st.exists && !st.avail;
      case (rq.cmd)
        CMD_FREE: begin
          if (st.exists && st.avail && st.in_use) begin
            frame_status[pg].in_use = 1'b0;
            rs.ok = 1'b1;
          end
        end
        CMD_ALLOC_RSV: begin
          if (reserved && !st.in_use) begin
            frame_status[pg].in_use = 1'b1;
            rs.ok   = 1'b1;
            rs.addr = frame_addr(int'(pg));
          end
        end
        CMD_FREE_RSV: begin
          if (reserved && st.in_use) begin
            frame_status[pg].in_use = 1'b0;
            rs.ok = 1'b1;
          end
        end
        CMD_QUERY_RSV: rs.ok = reserved;
        default: begin
          frame_status[pg].exists = rq.ld_exists;
          frame_status[pg].avail  = rq.ld_avail;
          frame_status[pg].in_use = rq.ld_in_use;
          rs.ok = 1'b1;
        end
      endcase
    end
    return rs;
  endfunction

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                           input logic e, input logic a, input logic u);
    frame_cmd_t c;
    c.cmd       = cmd;
    c.addr      = addr;
    c.ld_exists = e;
    c.ld_avail  = a;
    c.ld_in_use = u;
    cmd_backlog.push_back(c);
    n_queued++;
  endtask

  // mostly pages inside the phase window, some page zero and wild addresses
  task automatic queue_random(input int lo, input int hi);
    int r;
    int sel;
    logic [ADDR_W-1:0] addr;
    logic [CMD_W-1:0]  cmd;
    logic e, a, u;
    r = $urandom_range(0, 99);
    if (r < 4) addr = $urandom;
    else if (r < 8) addr = ADDR_W'($urandom_range(0, (1 << PAGE_SHIFT) - 1));
    else addr = frame_addr($urandom_range(lo, hi)) | ADDR_W'($urandom_range(0, 4095));
    sel = $urandom_range(0, 99);
    if (sel < 28) cmd = CMD_LOAD;
    else if (sel < 55) cmd = CMD_ALLOC;
    else if (sel < 70) cmd = CMD_FREE;
    else if (sel < 79) cmd = CMD_ALLOC_RSV;
    else if (sel < 88) cmd = CMD_FREE_RSV;
    else if (sel < 97) cmd = CMD_QUERY_RSV;
    else cmd = $urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      e = 1'b1; a = 1'b1; u = 1'b0;
    end else if (r < 75) begin
      e = 1'b1; a = 1'b0; u = 1'($urandom_range(0, 1));
    end else begin
      e = 1'($urandom_range(0, 1));
      a = 1'($urandom_range(0, 1));
      u = 1'($urandom_range(0, 1));
    end
    queue_cmd(cmd, addr, e, a, u);
  endtask

  task automatic cfg_write(input pfa_reg_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_FIRST_PAGE) begin
      cfg_first = val;
      scan_ptr  = PTR_W'(val);
    end else begin
      cfg_last = val;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (n_accepted != n_queued || pending_replies.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] first, input logic [CFG_W-1:0] last,
                           input int n);
    int lo, hi;
    lo = (first < last) ? int'(first) : int'(last);
    hi = (first < last) ? int'(last) : int'(first);
    lo = (lo > 3) ? lo - 3 : 0;
    hi = (hi + 4 > NUM_PAGES - 1) ? NUM_PAGES - 1 : hi + 4;
    wait_idle();
    cfg_write(REG_LAST_PAGE, last);
    cfg_write(REG_FIRST_PAGE, first);
    n_settings++;
    repeat (n) queue_random(lo, hi);
  endtask

  // command driver: bursts of random length, random gaps between them
  always @(negedge clk_i) begin : cmd_driver
    frame_cmd_t nxt;
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        req_bus.valid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        nxt = cmd_backlog.pop_front();
        req_bus.cmd            <= nxt.cmd;
        req_bus.phys_address   <= nxt.addr;
        req_bus.load_exists    <= nxt.ld_exists;
        req_bus.load_available <= nxt.ld_avail;
        req_bus.load_in_use    <= nxt.ld_in_use;
        req_bus.valid          <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // response receiver: switches at random between stall patterns
  always @(negedge clk_i) begin : rsp_receiver
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(RX_FREE, RX_STALLY);
      rx_mode_left = $urandom_range(10, 80);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_FREE:   rsp_bus.ready <= 1'b1;
      RX_CHOPPY: rsp_bus.ready <= 1'($urandom_range(0, 1));
      default:   rsp_bus.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // monitor: checks responses, then predicts for the accepted command
  always @(posedge clk_i) begin : bus_monitor
    frame_reply_t want;
    frame_cmd_t   seen;
    req_taken = 1'b0;
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("response with no command outstanding");
        end else begin
          want = pending_replies.pop_front();
          if (rsp_bus.ok !== want.ok)
            report_mismatch($sformatf("ok %b, expected %b", rsp_bus.ok, want.ok));
          if (rsp_bus.result_address !== want.addr)
            report_mismatch($sformatf("result_address %h, expected %h",
                                      rsp_bus.result_address, want.addr));
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        seen.cmd       = req_bus.cmd;
        seen.addr      = req_bus.phys_address;
        seen.ld_exists = req_bus.load_exists;
        seen.ld_avail  = req_bus.load_available;
        seen.ld_in_use = req_bus.load_in_use;
        want = frame_alloc_step(seen);
        pending_replies.push_back(want);
        n_accepted++;
        if (seen.cmd == CMD_ALLOC) begin
          n_alloc++;
          if (want.ok) n_alloc_ok++;
        end
        if (want.ok) n_ok++;
        req_taken = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    req_bus.valid          = 1'b0;
    req_bus.cmd            = CMD_ALLOC;
    req_bus.phys_address   = '0;
    req_bus.load_exists    = 1'b0;
    req_bus.load_available = 1'b0;
    req_bus.load_in_use    = 1'b0;
    rsp_bus.ready          = 1'b0;
    for (int p = 0; p < NUM_PAGES; p++) frame_status[p] = '0;
    scan_ptr  = '0;
    cfg_first = FIRST_PAGE_RST;
    cfg_last  = LAST_PAGE_RST;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // full-range setting; writes land during the clearing pass
    cfg_write(REG_FIRST_PAGE, 12'd0);
    cfg_write(REG_LAST_PAGE, 12'd4095);
    n_settings++;
    queue_cmd(CMD_LOAD, 32'h0000_0ABC, 1'b1, 1'b1, 1'b0);       // page zero
    queue_cmd(CMD_LOAD, 32'hFFFF_F000, 1'b1, 1'b1, 1'b0);       // past the store
    queue_cmd(CMD_LOAD, 32'h00FF_F000, 1'b1, 1'b1, 1'b0);
    queue_cmd(CMD_LOAD, 32'h0000_1FFF, 1'b1, 1'b1, 1'b0);
    queue_cmd(CMD_LOAD, 32'h0000_2000, 1'b1, 1'b0, 1'b0);
    queue_cmd(CMD_LOAD, 32'h0000_3123, 1'b1, 1'b0, 1'b1);
    queue_cmd(CMD_QUERY_RSV, 32'h0000_2000, 1'b0, 1'b0, 1'b0);
    queue_cmd(CMD_QUERY_RSV, 32'h0000_1000, 1'b0, 1'b0, 1'b0);
    queue_cmd(CMD_QUERY_RSV, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
    queue_cmd(CMD_ALLOC, 32'h0, 1'b0, 1'b0, 1'b0);               // skips page zero
    queue_cmd(CMD_ALLOC, 32'h0, 1'b0, 1'b0, 1'b0);               // top page, pointer past end
    queue_cmd(CMD_ALLOC, 32'h0, 1'b0, 1'b0, 1'b0);               // nothing free
    queue_cmd(CMD_FREE, 32'h0000_1000, 1'b0, 1'b0, 1'b0);
    queue_cmd(CMD_FREE, 32'h0000_1000, 1'b0, 1'b0, 1'b0);
    queue_cmd(CMD_FREE, 32'h0000_2000, 1'b0, 1'b0, 1'b0);
    queue_cmd(CMD_ALLOC_RSV, 32'h0000_2000, 1'b0, 1'b0, 1'b0);
    queue_cmd(CMD_ALLOC_RSV, 32'h0000_2000, 1'b0, 1'b0, 1'b0);
    queue_cmd(CMD_ALLOC_RSV, 32'h0000_1000, 1'b0, 1'b0, 1'b0);
    queue_cmd(CMD_FREE_RSV, 32'h0000_3000, 1'b0, 1'b0, 1'b0);
    queue_cmd(CMD_FREE_RSV, 32'h0000_3000, 1'b0, 1'b0, 1'b0);
    queue_cmd(CMD_FREE_RSV, 32'h0000_2000, 1'b0, 1'b0, 1'b0);
    queue_cmd(CMD_RSVD_6, 32'h0000_1000, 1'b1, 1'b1, 1'b1);
    queue_cmd(CMD_RSVD_7, 32'h00FF_F000, 1'b1, 1'b1, 1'b1);
    queue_cmd(CMD_FREE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    queue_cmd(CMD_ALLOC, 32'h0, 1'b0, 1'b0, 1'b0);

    run_phase(12'd1, 12'd48, 98);
    run_phase(12'd10, 12'd30, 98);
    run_phase(12'd0, 12'd0, 98);          // only page zero scanned
    run_phase(12'd25, 12'd12, 98);        // second pass empty
    run_phase(12'd4095, 12'd4095, 98);
    run_phase(12'd4060, 12'd4095, 98);
    run_phase(12'd0, 12'd63, 98);
    run_phase(12'd200, 12'd260, 98);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (pending_replies.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", pending_replies.size()));
    $display("testbench: %0d commands over %0d register settings, %0d ok responses",
             n_accepted, n_settings, n_ok);
    $display("testbench: %0d allocations, %0d granted, %0d mismatches",
             n_alloc, n_alloc_ok, n_errors);
    if (n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
